// ===== design/bffa_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, command codes and sequencer states of the bitmap first-fit allocator.
package bffa_pkg;

	localparam int POOL_BYTES_DEF = 8192;
	// percentage scale times Q8 one
	localparam int PCT_Q8 = 100 * 256;
	localparam int PCT_QW = 15;

	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_USAGE = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCAN,
		ST_MARK,
		ST_FREE,
		ST_USAGE,
		ST_MUL,
		ST_CLEAR,
		ST_FIN
	} state_t;

endpackage

// ===== design/bitmap_first_fit_allocator.sv =====
`timescale 1ns / 1ps
// Top level: usage map, word sequencer and reciprocal multiply of the first-fit allocator.
//
// One command item enters on the in channel (in_valid / in_stall) and gives exactly one
// result item on the out channel (out_valid / out_stall). The map holds one bit per pool
// byte in a single-port-write memory of MW = (POOL_BYTES+7)/8 eight-bit words, read one
// word per cycle with registered read data; every command but a zero-size allocate and a
// free at an offset outside the pool is a walk over that memory. The block takes one item
// at a time and holds in_stall high while it works.
//   Allocate: scans words until a free run fits, then restarts at the block's first word
//             and marks each word it covers; with no fit the scan ends at the last word.
//             A zero size is answered without a scan.
//   Free:     clears set bits from the offset on, stopping at the first clear bit.
//   Usage:    counts over every word, then a multiply step, then the result.
//   Clear:    writes zero to every word.
// After reset the block clears the whole map with in_stall high. A finished result sits
// in the output register; while the receiver stalls the block still takes the next item
// and only holds before delivering its result.
module bitmap_first_fit_allocator #(
	parameter int POOL_BYTES = bffa_pkg::POOL_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [13:0] req_size,
	input  logic [12:0] block_offset,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [12:0] alloc_offset,
	output logic [13:0] used_bytes,
	output logic [14:0] used_percent_q8
);
	import bffa_pkg::*;

	localparam int MW = (POOL_BYTES + 7) / 8;
	localparam int AW = $clog2(MW);
	localparam int BW = AW + 3;
	localparam int PW = $clog2(POOL_BYTES + 1);
	localparam int RW = (PW > 15) ? PW : 15;
	localparam int XW = (BW > 14) ? BW : 14;
	localparam int OW = (BW + 1 > 13) ? BW + 1 : 13;
	// scaled reciprocal of the pool size, exact for every count up to the pool size
	localparam int SH = 2 * PW;
	localparam longint RECIP = ((longint'(PCT_Q8) << SH) + longint'(POOL_BYTES) - 64'sd1)
		/ longint'(POOL_BYTES);
	localparam int RB = $clog2(RECIP + 64'sd1);
	localparam int QW = (PW + RB > SH + PCT_QW) ? PW + RB : SH + PCT_QW;

	state_t state_q, state_d;

	logic [7:0]        mem [MW];
	logic [7:0]        rdata_q;
	logic [AW-1:0]     addr_q;
	logic [AW-1:0]     daddr_q;
	logic              dv_q;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [7:0]        mem_wd;

	logic [1:0]        cmd_q;
	logic [13:0]       size_q;
	logic [RW-1:0]     need_q;
	logic [RW-1:0]     run_q;
	logic [BW-1:0]     lo_q;
	logic [BW-1:0]     hi_q;
	logic [2:0]        fbit_q;
	logic              first_q;
	logic [PW-1:0]     cnt_q;
	logic              prev_q;
	logic [QW-1:0]     prod_q;
	logic              fail_q;
	logic              out_valid_q;

	// word analysis
	logic [7:0]        valid_m;
	logic [7:0]        eff;
	logic [7:0]        scan_eff;
	logic              hit;
	logic [2:0]        hit_pos;
	logic [RW-1:0]     run_next;
	logic [BW-1:0]     end_b;
	logic [XW-1:0]     lo_x;
	logic [BW-1:0]     lo_b;
	logic [7:0]        mark_m;
	logic [7:0]        clr;
	logic [4:0]        wsum;
	logic              last_word;
	logic              can_load;
	logic              off_in_pool;
	logic [BW+12:0]    off_ext;
	logic [BW-1:0]     off_b;
	logic [BW+12:0]    aoff_ext;
	logic [PW+13:0]    used_ext;

	assign last_word   = (daddr_q == AW'(MW - 1));
	assign can_load    = !out_valid_q || !out_stall;
	assign off_in_pool = OW'(block_offset) < OW'(POOL_BYTES);
	assign off_ext     = {BW'(0), block_offset};
	assign off_b       = off_ext[BW-1:0];
	assign end_b       = {daddr_q, hit_pos};
	assign lo_x        = XW'(end_b) + XW'(1) - XW'(size_q);
	assign lo_b        = lo_x[BW-1:0];
	assign aoff_ext    = {13'd0, lo_q};
	assign used_ext    = {14'd0, cnt_q};

	always_comb begin
		logic [3:0]    tz;
		logic          full;
		logic [RW-1:0] run_i;
		logic          keep;
		logic [2:0]    start;
		logic [7:0]    rise;
		logic [BW:0]   ba;
		hit      = 1'b0;
		hit_pos  = 3'd0;
		run_next = run_q;
		tz       = 4'd0;
		full     = 1'b1;
		keep     = 1'b1;
		start    = first_q ? fbit_q : 3'd0;
		for (int i = 0; i < 8; i++) begin
			ba         = {1'b0, daddr_q, 3'(i)};
			valid_m[i] = ba < (BW + 1)'(POOL_BYTES);
			mark_m[i]  = (ba[BW-1:0] >= lo_q) && (ba[BW-1:0] <= hi_q);
		end
		eff      = rdata_q & valid_m;
		// bytes past the pool end act as used so no run reaches them
		scan_eff = rdata_q | ~valid_m;
		for (int i = 0; i < 8; i++) begin
			if (scan_eff[i]) begin
				tz   = 4'd0;
				full = 1'b0;
			end else begin
				tz = tz + 4'd1;
			end
			run_i = full ? run_q + RW'(i + 1) : RW'(tz);
			if (!hit && run_i == need_q) begin
				hit     = 1'b1;
				hit_pos = 3'(i);
			end
			run_next = run_i;
		end
		for (int i = 0; i < 8; i++) begin
			if (3'(i) >= start) begin
				keep   = keep & eff[i];
				clr[i] = keep;
			end else begin
				clr[i] = 1'b0;
			end
		end
		// count each used byte, and each free byte that sits right before a used one
		rise = eff & ~{eff[6:0], prev_q};
		wsum = 5'd0;
		for (int i = 0; i < 8; i++) begin
			wsum = wsum + 5'(eff[i]) + 5'(rise[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mem_we  = 1'b0;
		mem_wa  = addr_q;
		mem_wd  = 8'd0;
		unique case (state_q)
			ST_INIT, ST_CLEAR: begin
				mem_we = 1'b1;
				if (addr_q == AW'(MW - 1)) begin
					state_d = (state_q == ST_INIT) ? ST_IDLE : ST_FIN;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					unique case (cmd)
						CMD_ALLOC: state_d = (req_size == 14'd0) ? ST_FIN : ST_SCAN;
						CMD_FREE:  state_d = off_in_pool ? ST_FREE : ST_FIN;
						CMD_USAGE: state_d = ST_USAGE;
						CMD_CLEAR: state_d = ST_CLEAR;
						default:   state_d = ST_FIN;
					endcase
				end
			end
			ST_SCAN: begin
				if (dv_q) begin
					if (hit) begin
						state_d = ST_MARK;
					end else if (last_word) begin
						state_d = ST_FIN;
					end
				end
			end
			ST_MARK: begin
				mem_we = dv_q;
				mem_wa = daddr_q;
				mem_wd = rdata_q | mark_m;
				if (dv_q && daddr_q == hi_q[BW-1:3]) begin
					state_d = ST_FIN;
				end
			end
			ST_FREE: begin
				mem_we = dv_q;
				mem_wa = daddr_q;
				mem_wd = rdata_q & ~clr;
				if (dv_q && (!clr[7] || last_word)) begin
					state_d = ST_FIN;
				end
			end
			ST_USAGE: begin
				if (dv_q && last_word) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_FIN;
			ST_FIN: begin
				if (can_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[addr_q];
	end

	// sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			dv_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && can_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT, ST_CLEAR: begin
					addr_q <= (addr_q == AW'(MW - 1)) ? '0 : addr_q + AW'(1);
					dv_q   <= 1'b0;
				end
				ST_IDLE: begin
					dv_q <= 1'b0;
					if (in_valid) begin
						addr_q <= (cmd == CMD_FREE && off_in_pool) ? off_b[BW-1:3] : '0;
					end
				end
				ST_SCAN, ST_MARK, ST_FREE, ST_USAGE: begin
					dv_q <= 1'b1;
					if (addr_q != AW'(MW - 1)) begin
						addr_q <= addr_q + AW'(1);
					end
					// restart the walk at the first word of the found block
					if (state_q == ST_SCAN && dv_q && hit) begin
						addr_q <= lo_b[BW-1:3];
						dv_q   <= 1'b0;
					end
				end
				default: begin
					dv_q <= 1'b0;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN || state_q == ST_MARK || state_q == ST_FREE
				|| state_q == ST_USAGE) begin
			daddr_q <= addr_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd_q   <= cmd;
					size_q  <= req_size;
					need_q  <= RW'(req_size) + RW'(1);
					run_q   <= '0;
					cnt_q   <= '0;
					prev_q  <= 1'b1;
					first_q <= 1'b1;
					fbit_q  <= block_offset[2:0];
					fail_q  <= (cmd == CMD_ALLOC) && (req_size == 14'd0);
				end
			end
			ST_SCAN: begin
				if (dv_q) begin
					run_q <= run_next;
					if (hit) begin
						lo_q <= lo_b;
						hi_q <= end_b;
					end else if (last_word) begin
						fail_q <= 1'b1;
					end
				end
			end
			ST_FREE: begin
				if (dv_q) begin
					first_q <= 1'b0;
				end
			end
			ST_USAGE: begin
				if (dv_q) begin
					cnt_q  <= cnt_q + PW'(wsum);
					prev_q <= eff[7];
				end
			end
			ST_MUL: begin
				prod_q <= QW'(cnt_q) * QW'(RECIP);
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && can_load) begin
			status          <= fail_q;
			alloc_offset    <= (cmd_q == CMD_ALLOC && !fail_q) ? aoff_ext[12:0] : 13'd0;
			used_bytes      <= (cmd_q == CMD_USAGE) ? used_ext[13:0] : 14'd0;
			used_percent_q8 <= (cmd_q == CMD_USAGE) ? prod_q[SH +: PCT_QW] : '0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== dv/tb_bitmap_first_fit_allocator.sv =====
`timescale 1ns / 1ps
// Testbench for the bitmap first-fit allocator: directed table, random commands, bit-level predictor.
module tb_bitmap_first_fit_allocator;
	import bffa_pkg::*;

	localparam int POOL = POOL_BYTES_DEF;
	localparam int N_RANDOM = 580;
	localparam int HOLD_CYCLES = 4000;
	localparam int DRAIN_CYCLES = 2200;

	typedef struct packed {
		logic        status;
		logic [12:0] alloc_offset;
		logic [13:0] used_bytes;
		logic [14:0] used_pct;
	} reply_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [13:0] size;
		logic [12:0] offset;
		logic        typed;
		reply_t      want;
	} row_t;

	localparam reply_t R_ZERO = '0;
	localparam reply_t R_FAIL = '{1'b1, 13'd0, 14'd0, 15'd0};
	localparam reply_t R_AT_1 = '{1'b0, 13'd1, 14'd0, 15'd0};
	localparam reply_t R_FULL = '{1'b0, 13'd0, 14'd8192, 15'd25600};

	localparam int N_DIRECTED = 26;
	localparam row_t DIRECTED [N_DIRECTED] = '{
		'{CMD_USAGE, 14'd0,     13'd0,    1'b1, R_ZERO},
		'{CMD_ALLOC, 14'd0,     13'd0,    1'b1, R_FAIL},
		'{CMD_ALLOC, 14'd1,     13'd0,    1'b1, R_AT_1},
		'{CMD_FREE,  14'd0,     13'd1,    1'b1, R_ZERO},
		'{CMD_USAGE, 14'd0,     13'd0,    1'b1, R_ZERO},
		'{CMD_ALLOC, 14'd8191,  13'd0,    1'b1, R_AT_1},
		'{CMD_USAGE, 14'd0,     13'd0,    1'b1, R_FULL},
		'{CMD_ALLOC, 14'd1,     13'd0,    1'b1, R_FAIL},
		'{CMD_FREE,  14'd0,     13'd4000, 1'b1, R_ZERO},
		'{CMD_USAGE, 14'd0,     13'd0,    1'b0, R_ZERO},
		'{CMD_ALLOC, 14'd8192,  13'd0,    1'b1, R_FAIL},
		'{CMD_ALLOC, 14'd16383, 13'd8191, 1'b1, R_FAIL},
		'{CMD_CLEAR, 14'd16383, 13'd8191, 1'b1, R_ZERO},
		'{CMD_USAGE, 14'd0,     13'd0,    1'b1, R_ZERO},
		'{CMD_ALLOC, 14'd8192,  13'd0,    1'b1, R_FAIL},
		'{CMD_ALLOC, 14'd8191,  13'd0,    1'b1, R_AT_1},
		'{CMD_FREE,  14'd0,     13'd0,    1'b0, R_ZERO},
		'{CMD_FREE,  14'd0,     13'd8191, 1'b0, R_ZERO},
		'{CMD_USAGE, 14'd0,     13'd0,    1'b0, R_ZERO},
		'{CMD_CLEAR, 14'd0,     13'd0,    1'b1, R_ZERO},
		'{CMD_ALLOC, 14'd5,     13'd0,    1'b1, R_AT_1},
		'{CMD_ALLOC, 14'd3,     13'd0,    1'b0, R_ZERO},
		'{CMD_ALLOC, 14'd10,    13'd0,    1'b0, R_ZERO},
		'{CMD_FREE,  14'd0,     13'd7,    1'b0, R_ZERO},
		'{CMD_ALLOC, 14'd2,     13'd0,    1'b0, R_ZERO},
		'{CMD_USAGE, 14'd0,     13'd0,    1'b0, R_ZERO}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd = CMD_ALLOC;
	logic [13:0] req_size = '0;
	logic [12:0] block_offset = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        status;
	logic [12:0] alloc_offset;
	logic [13:0] used_bytes;
	logic [14:0] used_percent_q8;

	bit          pool_map [POOL];
	reply_t      expected_replies [$];
	int          live_blocks [$];
	int          mismatch_count = 0;
	int          results_seen = 0;
	bit          stimulus_done = 1'b0;
	bit          no_idle = 1'b0;

	bitmap_first_fit_allocator dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.cmd             (cmd),
		.req_size        (req_size),
		.block_offset    (block_offset),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.alloc_offset    (alloc_offset),
		.used_bytes      (used_bytes),
		.used_percent_q8 (used_percent_q8)
	);

	always #4 clk = ~clk;

	// Apply one command to the map copy and return the reply it gives.
	function automatic reply_t apply_command(logic [1:0] c, logic [13:0] s, logic [12:0] o);
		reply_t r;
		int run;
		int k;
		int first;
		longint cnt;
		r = '0;
		case (c)
			CMD_ALLOC: begin
				r.status = 1'b1;
				run = 0;
				if (s != 0) begin
					for (k = 0; k < POOL; k++) begin
						run = pool_map[k] ? 0 : run + 1;
						if (run == int'(s) + 1) begin
							first = k + 1 - int'(s);
							for (int t = first; t <= k; t++)
								pool_map[t] = 1'b1;
							r.status = 1'b0;
							r.alloc_offset = first[12:0];
							break;
						end
					end
				end
			end
			CMD_FREE: begin
				for (k = int'(o); k < POOL; k++) begin
					if (!pool_map[k])
						break;
					pool_map[k] = 1'b0;
				end
			end
			CMD_USAGE: begin
				cnt = 0;
				for (k = 0; k < POOL; k++) begin
					if (pool_map[k])
						cnt++;
					else if (k + 1 < POOL && pool_map[k + 1])
						cnt++;
				end
				r.used_bytes = cnt[13:0];
				r.used_pct = 15'((cnt * longint'(PCT_Q8)) / longint'(POOL));
			end
			CMD_CLEAR: begin
				for (k = 0; k < POOL; k++)
					pool_map[k] = 1'b0;
			end
		endcase
		return r;
	endfunction

	function automatic int draw_idle();
		return no_idle ? 0 : $urandom_range(0, 14);
	endfunction

	task automatic flag_mismatch(string what, longint got, longint want);
		mismatch_count++;
		$display("%0t ns: result %0d %s got %0d want %0d", $time, results_seen, what, got, want);
	endtask

	// Offer one item, hold it until taken, and queue its reply.
	task automatic offer(logic [1:0] c, logic [13:0] s, logic [12:0] o, logic typed,
			reply_t want);
		int gap;
		reply_t pred;
		gap = draw_idle();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		req_size <= s;
		block_offset <= o;
		do @(posedge clk); while (in_stall !== 1'b0);
		pred = apply_command(c, s, o);
		expected_replies.push_back(typed ? want : pred);
		if (c == CMD_ALLOC && pred.status == 1'b0)
			live_blocks.push_back(int'(pred.alloc_offset));
		else if (c == CMD_CLEAR)
			live_blocks.delete();
	endtask

	initial begin
		logic [1:0]  c;
		logic [13:0] s;
		logic [12:0] o;
		int roll;
		int idx;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < N_DIRECTED; i++)
			offer(DIRECTED[i].cmd, DIRECTED[i].size, DIRECTED[i].offset,
				DIRECTED[i].typed, DIRECTED[i].want);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 40 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			s = 14'($urandom());
			o = 13'($urandom());
			roll = $urandom_range(0, 99);
			if (roll < 45) begin
				c = CMD_ALLOC;
				roll = $urandom_range(0, 99);
				if (roll < 70)
					s = 14'($urandom_range(1, 64));
				else if (roll < 85)
					s = 14'($urandom_range(65, 1024));
				else if (roll < 93)
					s = 14'($urandom_range(1025, 8192));
				else if (roll < 97)
					s = '0;
				else
					s = 14'($urandom_range(8193, 16383));
			end else if (roll < 78) begin
				c = CMD_FREE;
				// mostly free a block that is really there
				if (live_blocks.size() != 0 && $urandom_range(0, 4) != 0) begin
					idx = $urandom_range(0, live_blocks.size() - 1);
					o = 13'(live_blocks[idx]);
					live_blocks.delete(idx);
				end
			end else if (roll < 96) begin
				c = CMD_USAGE;
			end else begin
				c = CMD_CLEAR;
			end
			offer(c, s, o, 1'b0, R_ZERO);
		end
		in_valid <= 1'b0;
		stimulus_done = 1'b1;
	end

	initial begin
		reply_t want;
		int w;
		wait (arst_n === 1'b1);
		forever begin
			// starve the output for a long stretch so the block backs up
			if (results_seen == 150 || results_seen == 420)
				w = HOLD_CYCLES;
			else
				w = draw_idle();
			if (w > 0) begin
				out_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			if (expected_replies.size() == 0) begin
				flag_mismatch("unexpected item, status", status, 0);
			end else begin
				want = expected_replies.pop_front();
				if (status !== want.status)
					flag_mismatch("status", status, want.status);
				if (alloc_offset !== want.alloc_offset)
					flag_mismatch("alloc_offset", alloc_offset, want.alloc_offset);
				if (used_bytes !== want.used_bytes)
					flag_mismatch("used_bytes", used_bytes, want.used_bytes);
				if (used_percent_q8 !== want.used_pct)
					flag_mismatch("used_percent_q8", used_percent_q8, want.used_pct);
			end
			results_seen++;
		end
	end

	initial begin
		wait (stimulus_done);
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_replies.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#(64'd60_000_000);
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/bffa_pkg.sv
design/bitmap_first_fit_allocator.sv
dv/tb_bitmap_first_fit_allocator.sv
